/* sv/hpm_pkg.sv */
package hpm_pkg;

    // Default geometry
    localparam int HPM_BINS        = 256;
    localparam int HPM_SAMPLE_BITS = 16;

    // Field widths
    localparam int NUM_CH    = 3;
    localparam int CMD_W     = 2;
    localparam int SAMPLE_W  = 16;
    localparam int BIN_SEL_W = 8;
    localparam int CH_SEL_W  = 2;
    localparam int COUNT_W   = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Channel select codes
    localparam logic [CH_SEL_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_SEL_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_SEL_W-1:0] CH_BLUE  = 2'd2;

    // Register map (word index), data bus width
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_CHANNEL_MASK = 1'b0;
    localparam logic REG_COLOR_MODE   = 1'b1;

    localparam logic [NUM_CH-1:0] CHANNEL_MASK_RESET = 3'b111;
    localparam logic              COLOR_MODE_RESET   = 1'b1;
    localparam logic [NUM_CH-1:0] ALLOW_RGB          = 3'b111;
    localparam logic [NUM_CH-1:0] ALLOW_LUMA         = 3'b001;

    // Per-cycle strobes from the sequencer to every lane
    typedef struct packed {
        logic mul_en;   // register sample times scale
        logic map_en;   // register bin index
        logic rd_en;    // read bin memory
        logic rd_sel;   // read at selected bin instead of mapped bin
        logic upd_en;   // write incremented count, update min/max
        logic clr_wr;   // clearing sweep write
        logic clr_mm;   // zero min/max
        logic seed;     // first pixel since clear
    } lane_ctrl_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  bin_count;
        logic [SAMPLE_W-1:0] channel_min;
        logic [SAMPLE_W-1:0] channel_max;
        logic                any_seen;
    } result_t;

endpackage

/* sv/hpm_if.sv */
interface hpm_pix_if;
    import hpm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [SAMPLE_W-1:0]  sample_red;
    logic [SAMPLE_W-1:0]  sample_green;
    logic [SAMPLE_W-1:0]  sample_blue;
    logic [BIN_SEL_W-1:0] bin_select;
    logic [CH_SEL_W-1:0]  channel_select;

    modport source (
        output valid, cmd, sample_red, sample_green, sample_blue, bin_select, channel_select,
        input  ready
    );
    modport sink (
        input  valid, cmd, sample_red, sample_green, sample_blue, bin_select, channel_select,
        output ready
    );
endinterface

interface hpm_res_if;
    import hpm_pkg::*;

    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  bin_count;
    logic [SAMPLE_W-1:0] channel_min;
    logic [SAMPLE_W-1:0] channel_max;
    logic                any_seen;

    modport source (
        output valid, bin_count, channel_min, channel_max, any_seen,
        input  ready
    );
    modport sink (
        input  valid, bin_count, channel_min, channel_max, any_seen,
        output ready
    );
endinterface

/* sv/hpm_binmap.sv */
module hpm_binmap #(
    parameter int BINS        = hpm_pkg::HPM_BINS,
    parameter int SAMPLE_BITS = hpm_pkg::HPM_SAMPLE_BITS
) (
    input  logic                    clk,
    input  hpm_pkg::lane_ctrl_t     ctrl,
    input  logic [SAMPLE_BITS-1:0]  sample,
    output logic [$clog2(BINS)-1:0] bin_idx
);
    import hpm_pkg::*;

    localparam int IDX_W = $clog2(BINS);
    localparam int NUM_W = SAMPLE_BITS + IDX_W;
    localparam int R_W   = ((SAMPLE_BITS > IDX_W) ? SAMPLE_BITS : IDX_W) + 1;
    localparam logic [NUM_W-1:0] SCALE   = NUM_W'(BINS - 1);
    localparam logic [R_W-1:0]   DIVISOR = R_W'((1 << SAMPLE_BITS) - 1);

    logic [NUM_W-1:0] product_reg;
    logic [IDX_W-1:0] bin_reg;
    logic [IDX_W-1:0] bin_next;
    logic [R_W-1:0]   q1, r1, q2, r2, quot;

    // Divide by 2^S-1: fold the high part back twice, then one correction
    always_comb
    begin
        q1       = R_W'(product_reg[NUM_W-1:SAMPLE_BITS]);
        r1       = R_W'(product_reg[SAMPLE_BITS-1:0]) + q1;
        q2       = r1 >> SAMPLE_BITS;
        r2       = R_W'(r1[SAMPLE_BITS-1:0]) + q2;
        quot     = q1 + q2 + ((r2 >= DIVISOR) ? R_W'(1) : R_W'(0));
        bin_next = quot[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            product_reg <= NUM_W'(sample) * SCALE;
        end
        if (ctrl.map_en)
        begin
            bin_reg <= bin_next;
        end
    end

    assign bin_idx = bin_reg;

endmodule

/* sv/hpm_lane.sv */
module hpm_lane #(
    parameter int BINS        = hpm_pkg::HPM_BINS,
    parameter int SAMPLE_BITS = hpm_pkg::HPM_SAMPLE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hpm_pkg::lane_ctrl_t          ctrl,
    input  logic                         enable,
    input  logic [hpm_pkg::SAMPLE_W-1:0] sample,
    input  logic [$clog2(BINS)-1:0]      sel_addr,
    input  logic [$clog2(BINS)-1:0]      clr_addr,
    output logic [hpm_pkg::COUNT_W-1:0]  count,
    output logic [hpm_pkg::SAMPLE_W-1:0] ch_min,
    output logic [hpm_pkg::SAMPLE_W-1:0] ch_max
);
    import hpm_pkg::*;

    localparam int IDX_W = $clog2(BINS);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    logic [COUNT_W-1:0]  mem [BINS];
    logic [COUNT_W-1:0]  rd_data_reg;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [SAMPLE_W-1:0] sample_sat;
    logic [IDX_W-1:0]    bin_idx;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [COUNT_W-1:0]  wr_data;
    logic                wr_en;

    // Clamp to the sample range
    assign sample_sat = (sample > SAMPLE_MAX) ? SAMPLE_MAX : sample;

    hpm_binmap #(
        .BINS        (BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_binmap (
        .clk     (clk),
        .ctrl    (ctrl),
        .sample  (sample_sat[SAMPLE_BITS-1:0]),
        .bin_idx (bin_idx)
    );

    // Memory port selection: sweep, increment or plain read
    assign rd_addr = ctrl.rd_sel ? sel_addr : bin_idx;
    assign wr_en   = ctrl.clr_wr | (ctrl.upd_en & enable);
    assign wr_addr = ctrl.clr_wr ? clr_addr : bin_idx;
    assign wr_data = ctrl.clr_wr ? '0 :
                     ((rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Running min/max, seeded by the first pixel
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.clr_mm)
        begin
            min_next = '0;
            max_next = '0;
        end
        else if (ctrl.upd_en && enable)
        begin
            if (ctrl.seed)
            begin
                min_next = sample_sat;
                max_next = sample_sat;
            end
            else
            begin
                if (sample_sat < min_reg)
                begin
                    min_next = sample_sat;
                end
                if (sample_sat > max_reg)
                begin
                    max_next = sample_sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign count  = rd_data_reg;
    assign ch_min = min_reg;
    assign ch_max = max_reg;

endmodule

/* sv/hpm_merge.sv */
module hpm_merge (
    input  logic [hpm_pkg::NUM_CH-1:0][hpm_pkg::COUNT_W-1:0]  counts,
    input  logic [hpm_pkg::NUM_CH-1:0][hpm_pkg::SAMPLE_W-1:0] mins,
    input  logic [hpm_pkg::NUM_CH-1:0][hpm_pkg::SAMPLE_W-1:0] maxs,
    input  logic [hpm_pkg::CH_SEL_W-1:0]                      channel_select,
    input  logic                                              in_range,
    input  logic                                              first_done,
    output hpm_pkg::result_t                                  result
);
    import hpm_pkg::*;

    logic [COUNT_W-1:0] count_sel;

    // Pick the selected lane; no channel reads as zeros
    always_comb
    begin
        count_sel          = '0;
        result.channel_min = '0;
        result.channel_max = '0;
        unique case (channel_select)
            CH_RED:
            begin
                count_sel          = counts[0];
                result.channel_min = mins[0];
                result.channel_max = maxs[0];
            end
            CH_GREEN:
            begin
                count_sel          = counts[1];
                result.channel_min = mins[1];
                result.channel_max = maxs[1];
            end
            CH_BLUE:
            begin
                count_sel          = counts[2];
                result.channel_min = mins[2];
                result.channel_max = maxs[2];
            end
            default:
            begin
                count_sel = '0;
            end
        endcase
        result.bin_count = in_range ? count_sel : '0;
        result.any_seen  = first_done;
    end

endmodule

/* sv/pixel_histogram_min_max_top.sv */
// Three-channel pixel histogram with running min/max. Each color channel has
// its own lane (bin memory of BINS 16-bit saturating counts, min/max registers
// and a bin mapper v*(BINS-1)/(2^SAMPLE_BITS-1)); a merge stage selects the
// lane for a read. Items are handled one at a time: a pixel goes through
// accept, multiply, divide, memory read and write back; a read through accept,
// memory read and output, plus any wait for the output register to drain; an
// unused command through accept only. The bin memory has one read-modify-write
// path per lane, which sets the pixel latency. A clear command, and reset,
// start a clearing pass that writes every bin to zero; no item is accepted
// during it, while register writes over the APB port are taken at any time.
// Register 0 (byte 0) is the channel mask, register 1 (byte 4) the color mode.
module pixel_histogram_min_max_top #(
    parameter int BINS        = hpm_pkg::HPM_BINS,
    parameter int SAMPLE_BITS = hpm_pkg::HPM_SAMPLE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    hpm_pix_if.sink                        pix_in,
    hpm_res_if.source                      res_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hpm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hpm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hpm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import hpm_pkg::*;

    localparam int IDX_W = $clog2(BINS);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(BINS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_MAP,
        S_RD,
        S_UPD,
        S_OUT
    } state_t;

    state_t                               state_reg;
    logic [IDX_W-1:0]                     clr_cnt_reg;
    logic                                 first_done_reg;
    logic                                 out_valid_reg;
    result_t                              out_reg;
    logic [NUM_CH-1:0]                    channel_mask_reg;
    logic                                 color_mode_reg;
    logic [CMD_W-1:0]                     cmd_reg;
    logic [NUM_CH-1:0][SAMPLE_W-1:0]      sample_reg;
    logic [BIN_SEL_W-1:0]                 bin_sel_reg;
    logic [CH_SEL_W-1:0]                  ch_sel_reg;
    logic                                 in_accept;
    logic                                 cfg_write;
    logic [NUM_CH-1:0]                    enabled;
    logic [IDX_W-1:0]                     sel_addr;
    logic                                 in_range;
    lane_ctrl_t                           lane_ctrl;
    logic [NUM_CH-1:0][COUNT_W-1:0]       lane_count;
    logic [NUM_CH-1:0][SAMPLE_W-1:0]      lane_min;
    logic [NUM_CH-1:0][SAMPLE_W-1:0]      lane_max;
    result_t                              result;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_mask_reg <= CHANNEL_MASK_RESET;
            color_mode_reg   <= COLOR_MODE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_CHANNEL_MASK: channel_mask_reg <= pwdata[NUM_CH-1:0];
                REG_COLOR_MODE:   color_mode_reg   <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CHANNEL_MASK: prdata = APB_DATA_W'(channel_mask_reg);
            REG_COLOR_MODE:   prdata = APB_DATA_W'(color_mode_reg);
            default:          prdata = '0;
        endcase
    end

    // Input item capture
    assign pix_in.ready = (state_reg == S_IDLE);
    assign in_accept    = pix_in.valid & pix_in.ready;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg       <= pix_in.cmd;
            sample_reg[0] <= pix_in.sample_red;
            sample_reg[1] <= pix_in.sample_green;
            sample_reg[2] <= pix_in.sample_blue;
            bin_sel_reg   <= pix_in.bin_select;
            ch_sel_reg    <= pix_in.channel_select;
        end
    end

    // Lane strobes
    assign enabled  = channel_mask_reg & (color_mode_reg ? ALLOW_RGB : ALLOW_LUMA);
    assign sel_addr = IDX_W'(bin_sel_reg);
    assign in_range = (32'(bin_sel_reg) < 32'(BINS));

    always_comb
    begin
        lane_ctrl.mul_en = (state_reg == S_MUL);
        lane_ctrl.map_en = (state_reg == S_MAP);
        lane_ctrl.rd_en  = (state_reg == S_RD);
        lane_ctrl.rd_sel = (cmd_reg == CMD_READ);
        lane_ctrl.upd_en = (state_reg == S_UPD);
        lane_ctrl.clr_wr = (state_reg == S_CLEAR);
        lane_ctrl.clr_mm = (state_reg == S_CLEAR);
        lane_ctrl.seed   = ~first_done_reg;
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        hpm_lane #(
            .BINS        (BINS),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .enable   (enabled[c]),
            .sample   (sample_reg[c]),
            .sel_addr (sel_addr),
            .clr_addr (clr_cnt_reg),
            .count    (lane_count[c]),
            .ch_min   (lane_min[c]),
            .ch_max   (lane_max[c])
        );
    end

    hpm_merge u_merge (
        .counts         (lane_count),
        .mins           (lane_min),
        .maxs           (lane_max),
        .channel_select (ch_sel_reg),
        .in_range       (in_range),
        .first_done     (first_done_reg),
        .result         (result)
    );

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            first_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            // Drain the output register; a read in S_OUT refills it itself
            if (out_valid_reg && res_out.ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clr_cnt_reg == CLR_LAST)
                    begin
                        clr_cnt_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (pix_in.valid)
                    begin
                        unique case (pix_in.cmd)
                            CMD_PIXEL: state_reg <= S_MUL;
                            CMD_READ:  state_reg <= S_RD;
                            CMD_CLEAR:
                            begin
                                first_done_reg <= 1'b0;
                                state_reg      <= S_CLEAR;
                            end
                            default:   state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_MUL: state_reg <= S_MAP;
                S_MAP: state_reg <= S_RD;
                S_RD:
                begin
                    state_reg <= (cmd_reg == CMD_READ) ? S_OUT : S_UPD;
                end
                S_UPD:
                begin
                    first_done_reg <= 1'b1;
                    state_reg      <= S_IDLE;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || res_out.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= result;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.bin_count   = out_reg.bin_count;
    assign res_out.channel_min = out_reg.channel_min;
    assign res_out.channel_max = out_reg.channel_max;
    assign res_out.any_seen    = out_reg.any_seen;

endmodule
